@@ rtl/tms_pkg.sv @@
`timescale 1ns / 1ps

package tms_pkg;

    localparam int SET_SIZE = 10;

    localparam int SCORE_W = 16;
    localparam int SUM_W   = 21;
    localparam int CNT_W   = 5;
    localparam int TRIM_W  = 2;

    // remaining scores after trimming one or two from each end
    localparam int KEPT_LIGHT = SET_SIZE - 2;
    localparam int KEPT_HEAVY = (SET_SIZE - 4 == 0) ? 1 : SET_SIZE - 4;

    // (x * recip) >> RECIP_SHIFT equals x / kept for any x below 2**SUM_W
    // as long as kept is no more than 17
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_LIGHT =
        RECIP_W'(((1 << RECIP_SHIFT) + KEPT_LIGHT - 1) / KEPT_LIGHT);
    localparam logic [RECIP_W-1:0] RECIP_HEAVY =
        RECIP_W'(((1 << RECIP_SHIFT) + KEPT_HEAVY - 1) / KEPT_HEAVY);

    localparam logic [TRIM_W-1:0] TRIM_LIGHT = 2'd1;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_L0,
        S_L1,
        S_S0,
        S_S1,
        S_R_L0,
        S_R_S0,
        S_R_L1,
        S_R_S1,
        S_DONE
    } state_t;

endpackage

@@ rtl/tms_alu.sv @@
`timescale 1ns / 1ps

module tms_alu (
    input  tms_pkg::alu_op_t             op,
    input  logic [tms_pkg::SUM_W-1:0]    a,
    input  logic [tms_pkg::SUM_W-1:0]    b,
    output logic [tms_pkg::SUM_W-1:0]    y,
    output logic                         carry
);

    logic [tms_pkg::SUM_W:0] full;

    // carry doubles as borrow on subtract: set when b > a
    always_comb
    begin
        case (op)
            tms_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
            tms_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default:          full = {1'b0, a} + {1'b0, b};
        endcase
        y     = full[tms_pkg::SUM_W-1:0];
        carry = full[tms_pkg::SUM_W];
    end

endmodule

@@ rtl/trimmed_mean_of_scores.sv @@
`timescale 1ns / 1ps

// channel   direction  signals               notes
// request   in/out     start, busy, score    taken when start && !busy
// result    out        done, mean            one-cycle strobe, no back-pressure
// config    in         cfg_we, cfg_data      trim count, written when cfg_we
//
// a score that does not close the set keeps busy high after it is taken
// while it is summed and then compared once or twice on each end, all through
// one shared 21-bit adder/subtractor. the last score of a set adds 2 or 4 trim
// subtracts on the same unit and one state that divides by a reciprocal
// multiply, and busy stays high through them; done rises in the same cycle
// that busy drops. reset clears the set and sets the trim count to one.
// the receiver cannot stall: done and mean are valid for one cycle only.

module trimmed_mean_of_scores (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tms_pkg::SCORE_W-1:0]       score,
    output logic                              done,
    output logic [tms_pkg::SCORE_W-1:0]       mean,
    input  logic                              cfg_we,
    input  logic [tms_pkg::TRIM_W-1:0]        cfg_data
);

    localparam int SW = tms_pkg::SUM_W;
    localparam int QW = tms_pkg::SCORE_W;

    localparam logic [QW-1:0] ONES = {QW{1'b1}};

    tms_pkg::state_t state_reg, state_next;

    logic [tms_pkg::TRIM_W-1:0] trim_reg;
    logic [QW-1:0]              score_reg, score_next;
    logic [SW-1:0]              sum_reg, sum_next;
    logic [tms_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [QW-1:0]              l0_reg, l0_next, l1_reg, l1_next;
    logic [QW-1:0]              s0_reg, s0_next, s1_reg, s1_next;
    logic [SW-1:0]              acc_reg, acc_next;
    logic                       done_reg, done_next;
    logic [QW-1:0]              mean_reg, mean_next;

    tms_pkg::alu_op_t alu_op;
    logic [SW-1:0]    alu_a, alu_b, alu_y;
    logic             alu_c;

    logic [SW-1:0]               score_ext;
    logic [tms_pkg::RECIP_W-1:0] recip;
    logic [tms_pkg::PROD_W-1:0]  product;
    logic                        last_score;

    tms_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .y     (alu_y),
        .carry (alu_c)
    );

    assign score_ext  = {{(SW-QW){1'b0}}, score_reg};
    assign recip      = (trim_reg == tms_pkg::TRIM_LIGHT) ? tms_pkg::RECIP_LIGHT
                                                          : tms_pkg::RECIP_HEAVY;
    assign product    = {{tms_pkg::RECIP_W{1'b0}}, acc_reg} * {{SW{1'b0}}, recip};
    assign last_score = (count_reg == tms_pkg::CNT_W'(tms_pkg::SET_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tms_pkg::S_IDLE;
            trim_reg  <= tms_pkg::TRIM_LIGHT;
            sum_reg   <= '0;
            count_reg <= '0;
            l0_reg    <= '0;
            l1_reg    <= '0;
            s0_reg    <= ONES;
            s1_reg    <= ONES;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                trim_reg <= cfg_data;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            l0_reg    <= l0_next;
            l1_reg    <= l1_next;
            s0_reg    <= s0_next;
            s1_reg    <= s1_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        acc_reg   <= acc_next;
        mean_reg  <= mean_next;
    end

    always_comb
    begin
        state_next = state_reg;
        score_next = score_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        l0_next    = l0_reg;
        l1_next    = l1_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        mean_next  = mean_reg;
        alu_op     = tms_pkg::ALU_SUB;
        alu_a      = '0;
        alu_b      = '0;

        case (state_reg)
            tms_pkg::S_IDLE:
            begin
                if (start)
                begin
                    score_next = score;
                    state_next = tms_pkg::S_ADD;
                end
            end
            tms_pkg::S_ADD:
            begin
                alu_op     = tms_pkg::ALU_ADD;
                alu_a      = sum_reg;
                alu_b      = score_ext;
                sum_next   = alu_y;
                count_next = count_reg + 1'b1;
                state_next = tms_pkg::S_L0;
            end
            tms_pkg::S_L0:
            begin
                // borrow on l0 - score means score is the new largest
                alu_a = {{(SW-QW){1'b0}}, l0_reg};
                alu_b = score_ext;
                if (alu_c)
                begin
                    l1_next    = l0_reg;
                    l0_next    = score_reg;
                    state_next = tms_pkg::S_S0;
                end
                else
                begin
                    state_next = tms_pkg::S_L1;
                end
            end
            tms_pkg::S_L1:
            begin
                alu_a = {{(SW-QW){1'b0}}, l1_reg};
                alu_b = score_ext;
                if (alu_c)
                begin
                    l1_next = score_reg;
                end
                state_next = tms_pkg::S_S0;
            end
            tms_pkg::S_S0:
            begin
                alu_a = score_ext;
                alu_b = {{(SW-QW){1'b0}}, s0_reg};
                if (alu_c)
                begin
                    s1_next    = s0_reg;
                    s0_next    = score_reg;
                    state_next = last_score ? tms_pkg::S_R_L0 : tms_pkg::S_IDLE;
                end
                else
                begin
                    state_next = tms_pkg::S_S1;
                end
            end
            tms_pkg::S_S1:
            begin
                alu_a = score_ext;
                alu_b = {{(SW-QW){1'b0}}, s1_reg};
                if (alu_c)
                begin
                    s1_next = score_reg;
                end
                state_next = last_score ? tms_pkg::S_R_L0 : tms_pkg::S_IDLE;
            end
            tms_pkg::S_R_L0:
            begin
                alu_a      = sum_reg;
                alu_b      = {{(SW-QW){1'b0}}, l0_reg};
                acc_next   = alu_y;
                state_next = tms_pkg::S_R_S0;
            end
            tms_pkg::S_R_S0:
            begin
                alu_a    = acc_reg;
                alu_b    = {{(SW-QW){1'b0}}, s0_reg};
                acc_next = alu_y;
                state_next = (trim_reg == tms_pkg::TRIM_LIGHT) ? tms_pkg::S_DONE
                                                               : tms_pkg::S_R_L1;
            end
            tms_pkg::S_R_L1:
            begin
                alu_a      = acc_reg;
                alu_b      = {{(SW-QW){1'b0}}, l1_reg};
                acc_next   = alu_y;
                state_next = tms_pkg::S_R_S1;
            end
            tms_pkg::S_R_S1:
            begin
                alu_a      = acc_reg;
                alu_b      = {{(SW-QW){1'b0}}, s1_reg};
                acc_next   = alu_y;
                state_next = tms_pkg::S_DONE;
            end
            tms_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                // quotient sits above the reciprocal's fraction bits
                mean_next  = product[tms_pkg::RECIP_SHIFT +: QW];
                sum_next   = '0;
                count_next = '0;
                l0_next    = '0;
                l1_next    = '0;
                s0_next    = ONES;
                s1_next    = ONES;
                state_next = tms_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tms_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tms_pkg::S_IDLE);
    assign done = done_reg;
    assign mean = mean_reg;

endmodule

@@ bench/tb_trimmed_mean_of_scores.sv @@
`timescale 1ns / 1ps

module tb_trimmed_mean_of_scores;

    localparam int CLK_HALF     = 6;
    localparam int QUIET_CYCLES = 40;     // longer than a full closing-score pass
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_SETS  = 90;

    typedef enum logic [1:0] {
        REQ_SCORE,
        REQ_TRIM,
        REQ_HOLD
    } req_kind_t;

    typedef struct {
        req_kind_t                    kind;
        logic [tms_pkg::SCORE_W-1:0]  score;
        logic [tms_pkg::TRIM_W-1:0]   trim;
    } req_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         start    = 1'b0;
    logic                         busy;
    logic [tms_pkg::SCORE_W-1:0]  score    = '0;
    logic                         done;
    logic [tms_pkg::SCORE_W-1:0]  mean;
    logic                         cfg_we   = 1'b0;
    logic [tms_pkg::TRIM_W-1:0]   cfg_data = '0;

    trimmed_mean_of_scores dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .score    (score),
        .done     (done),
        .mean     (mean),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // running tally of the open set, mirrored from the block
    logic [tms_pkg::SUM_W-1:0]    sum_acc;
    logic [tms_pkg::CNT_W-1:0]    seen_cnt;
    logic [tms_pkg::SCORE_W-1:0]  top_hi [2];
    logic [tms_pkg::SCORE_W-1:0]  bot_lo [2];
    logic [tms_pkg::TRIM_W-1:0]   trim_reg;

    req_t                         pending [$];
    logic [tms_pkg::SCORE_W-1:0]  mean_q [$];
    int                           fails      = 0;
    int                           cycle_cnt  = 0;
    int                           gap_left   = 0;
    int                           burst_left = 0;
    int                           quiet      = 0;

    logic                         go;
    logic [tms_pkg::SCORE_W-1:0]  go_score;
    logic                         we;
    logic [tms_pkg::TRIM_W-1:0]   wdata;
    req_t                         head;

    function automatic void clear_tally();
        sum_acc   = '0;
        seen_cnt  = '0;
        top_hi[0] = '0;
        top_hi[1] = '0;
        bot_lo[0] = '1;
        bot_lo[1] = '1;
    endfunction

    function automatic void fold_score(input logic [tms_pkg::SCORE_W-1:0] s);
        int unsigned trimmed_out;
        int unsigned divisor;
        sum_acc  = sum_acc + s;
        seen_cnt = seen_cnt + 1'b1;
        if (s > top_hi[0])
        begin
            top_hi[1] = top_hi[0];
            top_hi[0] = s;
        end
        else if (s > top_hi[1])
        begin
            top_hi[1] = s;
        end
        if (s < bot_lo[0])
        begin
            bot_lo[1] = bot_lo[0];
            bot_lo[0] = s;
        end
        else if (s < bot_lo[1])
        begin
            bot_lo[1] = s;
        end
        if (seen_cnt < tms_pkg::SET_SIZE)
            return;
        // anything but the light trim drops two from each end
        if (trim_reg == tms_pkg::TRIM_LIGHT)
        begin
            trimmed_out = top_hi[0] + bot_lo[0];
            divisor     = tms_pkg::KEPT_LIGHT;
        end
        else
        begin
            trimmed_out = top_hi[0] + top_hi[1] + bot_lo[0] + bot_lo[1];
            divisor     = tms_pkg::KEPT_HEAVY;
        end
        mean_q.push_back(tms_pkg::SCORE_W'((sum_acc - trimmed_out) / divisor));
        clear_tally();
    endfunction

    function automatic void push_score(input logic [tms_pkg::SCORE_W-1:0] s);
        req_t r;
        r.kind  = REQ_SCORE;
        r.score = s;
        r.trim  = '0;
        pending.push_back(r);
    endfunction

    function automatic void push_trim(input logic [tms_pkg::TRIM_W-1:0] t);
        req_t r;
        r.kind  = REQ_TRIM;
        r.score = '0;
        r.trim  = t;
        pending.push_back(r);
    endfunction

    function automatic void push_hold();
        req_t r;
        r.kind  = REQ_HOLD;
        r.score = '0;
        r.trim  = '0;
        pending.push_back(r);
    endfunction

    // score shapes: uniform, extremes, near-ties around a base, constant set
    function automatic logic [tms_pkg::SCORE_W-1:0] pick_score(
        input int mode,
        input logic [tms_pkg::SCORE_W-1:0] base);
        logic [tms_pkg::SCORE_W-1:0] v;
        case (mode)
            0: v = tms_pkg::SCORE_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = base;
                endcase
            end
            2: v = base ^ tms_pkg::SCORE_W'($urandom_range(0, 3));
            default: v = base;
        endcase
        return v;
    endfunction

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver: launches queued scores in bursts, writes the trim when idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            score    <= '0;
            cfg_we   <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            go       = start;
            go_score = score;
            we       = 1'b0;
            wdata    = cfg_data;
            if (start && !busy)
            begin
                fold_score(score);
                go = 1'b0;
            end
            if (!go)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (pending.size() != 0)
                begin
                    head = pending[0];
                    if (head.kind == REQ_SCORE)
                    begin
                        go       = 1'b1;
                        go_score = head.score;
                        void'(pending.pop_front());
                        if (burst_left == 0)
                        begin
                            burst_left = $urandom_range(1, 48);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 45);
                        end
                        else
                        begin
                            burst_left--;
                        end
                    end
                    else if (mean_q.size() != 0 || busy)
                    begin
                        quiet = 0;
                    end
                    else if (quiet < QUIET_CYCLES)
                    begin
                        quiet++;
                    end
                    else
                    begin
                        quiet = 0;
                        void'(pending.pop_front());
                        if (head.kind == REQ_TRIM)
                        begin
                            we       = 1'b1;
                            wdata    = head.trim;
                            trim_reg = head.trim;
                        end
                    end
                end
            end
            start    <= go;
            score    <= go_score;
            cfg_we   <= we;
            cfg_data <= wdata;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (mean_q.size() == 0)
            begin
                $error("mean: expected none, got %h", mean);
                fails++;
            end
            else if (mean !== mean_q[0])
            begin
                $error("mean: expected %h, got %h", mean_q[0], mean);
                fails++;
                void'(mean_q.pop_front());
            end
            else
            begin
                void'(mean_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int                           mode;
        int                           mid;
        logic [tms_pkg::SCORE_W-1:0]  base;
        logic [tms_pkg::TRIM_W-1:0]   trim_seq [6];

        clear_tally();
        trim_reg = tms_pkg::TRIM_LIGHT;
        trim_seq = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};

        // light trim from reset, extremes and tied highs and lows
        push_score(16'hFFFF);
        push_score(16'h0000);
        push_score(16'hFFFF);
        push_score(16'h0000);
        push_score(16'h8000);
        push_score(16'h7FFF);
        push_score(16'h0100);
        push_score(16'h00FF);
        push_score(16'hAAAA);
        push_score(16'h5555);
        push_hold();
        push_trim(2'd2);
        // trim rewritten halfway through a set, full-scale scores after it
        push_score(16'h1234);
        push_score(16'h0001);
        push_score(16'hFFFE);
        push_score(16'h0F0F);
        push_score(16'hF0F0);
        push_trim(2'd0);
        repeat (5) push_score(16'hFFFF);

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            if (s % 10 == 0)
                push_trim((s / 10 < 6) ? trim_seq[s / 10]
                                       : tms_pkg::TRIM_W'($urandom_range(0, 3)));
            else if ($urandom_range(0, 19) == 0)
                push_hold();
            mode = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1;
                default: base = tms_pkg::SCORE_W'($urandom);
            endcase
            mid = ($urandom_range(0, 14) == 0) ? $urandom_range(1, tms_pkg::SET_SIZE - 1) : 0;
            for (int i = 0; i < tms_pkg::SET_SIZE; i++)
            begin
                if (mid != 0 && i == mid)
                    push_trim(tms_pkg::TRIM_W'($urandom_range(0, 3)));
                push_score(pick_score(mode, base));
            end
        end

        @(posedge rst_n);
        while (pending.size() != 0 || start || busy || mean_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fails == 0 && mean_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
